FILE: sv/rspt_pkg.sv
// ----------------------------------------------------------------------------
// rspt_pkg: shared types and codes for the ranked sorted pair table
// Transaction payloads, cell storage word, cell command word, op and status
// codes.
// ----------------------------------------------------------------------------
package rspt_pkg;

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_DELETE = 3'd1;
  localparam logic [2:0] KIND_UPDATE = 3'd2;
  localparam logic [2:0] KIND_SEARCH = 3'd3;
  localparam logic [2:0] KIND_FETCH  = 3'd4;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] score;
    logic signed [31:0] value;
    logic signed [31:0] prior_score;
    logic [8:0]         position;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [8:0]         rank;
    logic signed [31:0] found_score;
    logic signed [31:0] found_value;
    logic [8:0]         entry_total;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] score;
    logic signed [31:0] value;
  } entry_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic               cmp;    // latch compare flags
    logic               ins;    // open a slot and shift right
    logic               del;    // close the matched slot and shift left
    logic               srch;   // flag the first equal score
    logic               fetch;  // flag the addressed position
    logic signed [31:0] score;
    logic signed [31:0] value;
    logic [8:0]         position;
  } cell_cmd_t;

endpackage

FILE: sv/rspt_cell.sv
// ----------------------------------------------------------------------------
// rspt_cell: one slot of the sorted row
// Holds one pair, latches its compare flags against the broadcast key and
// takes its left or right neighbor's pair when the row shifts.
// ----------------------------------------------------------------------------
module rspt_cell
  import rspt_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 9
) (
  input  logic       clk,
  input  cell_cmd_t  cmd,
  input  logic [CNT_W-1:0] count,
  input  entry_t     left_ent,
  input  entry_t     right_ent,
  input  logic       left_gt,
  input  logic       left_eq,
  input  logic       seen_in,
  output entry_t     ent,
  output logic       gt,
  output logic       eq,
  output logic       seen_out,
  output logic       hit
);

  logic occupied;
  logic mt;
  logic pos;

  assign occupied = 32'(INDEX) < 32'(count);

  // Empty slots sort after every key, so the insert point stays monotone.
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      gt  <= !occupied || (ent.score > cmd.score);
      eq  <= occupied && (ent.score == cmd.score);
      mt  <= occupied && (ent.score == cmd.score) && (ent.value == cmd.value);
      pos <= occupied && (32'(cmd.position) == 32'(INDEX + 1));
    end
  end

  assign seen_out = seen_in | mt;
  assign hit      = (cmd.srch & eq & ~left_eq) | (cmd.fetch & pos);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (left_gt) begin
        ent <= left_ent;
      end else if (gt) begin
        ent <= '{score: cmd.score, value: cmd.value};
      end
    end else if (cmd.del && seen_out) begin
      ent <= right_ent;
    end
  end

endmodule

FILE: sv/rspt_select.sv
// ----------------------------------------------------------------------------
// rspt_select: result picker
// Reduces the one-hot hit flags of the row to the flagged pair and its rank.
// ----------------------------------------------------------------------------
module rspt_select
  import rspt_pkg::*;
#(
  parameter int N = 256
) (
  input  logic         clk,
  input  logic         load,
  input  logic [N-1:0] hit,
  input  entry_t       ents [N],
  output logic         any,
  output logic [8:0]   rank,
  output entry_t       ent
);

  logic       any_next;
  logic [8:0] rank_next;
  entry_t     ent_next;

  // At most one hit is set, so an AND-OR reduction picks it.
  always_comb begin
    any_next  = 1'b0;
    rank_next = '0;
    ent_next  = '0;
    for (int i = 0; i < N; i++) begin
      any_next  = any_next | hit[i];
      rank_next = rank_next | (hit[i] ? 9'(i + 1) : 9'd0);
      ent_next  = ent_next | (hit[i] ? ents[i] : entry_t'('0));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      any  <= any_next;
      rank <= rank_next;
      ent  <= ent_next;
    end
  end

endmodule

FILE: sv/ranked_sorted_pair_table.sv
// ----------------------------------------------------------------------------
// ranked_sorted_pair_table: sorted (score, value) multiset with rank queries
// Flow: a request passes through ST_CMP, ST_ACT and ST_DONE; update makes a
// delete pass and then an insert pass through the cell row. A new request is
// taken only in ST_IDLE, after the last response is loaded; each pass is a
// compare state and a shift or select state across all cells at once.
// Reset: the entry count clears to zero at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ranked_sorted_pair_table
  import rspt_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_ACT  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t           state;
  req_t             cur;
  logic             second;
  logic [CNT_W-1:0] entry_count;
  logic [1:0]       res_status;

  cell_cmd_t             cmd;
  entry_t                ents [CAPACITY];
  logic [CAPACITY-1:0]   gts;
  logic [CAPACITY-1:0]   eqs;
  logic [CAPACITY-1:0]   hits;
  logic [CAPACITY:0]     seen;

  logic       is_ins_pass;
  logic       is_del_pass;
  logic       is_query;
  logic       ins_ok;
  logic       found;
  logic       rsp_load;
  logic       sel_any;
  logic [8:0] sel_rank;
  entry_t     sel_ent;

  assign req_ready   = (state == ST_IDLE);
  assign is_ins_pass = (cur.kind == KIND_INSERT) || ((cur.kind == KIND_UPDATE) && second);
  assign is_del_pass = (cur.kind == KIND_DELETE) || ((cur.kind == KIND_UPDATE) && !second);
  assign is_query    = (cur.kind == KIND_SEARCH) || (cur.kind == KIND_FETCH);
  assign ins_ok      = entry_count != CNT_W'(CAPACITY);
  assign found       = seen[CAPACITY];
  assign seen[0]     = 1'b0;
  assign rsp_load    = (state == ST_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    cmd.cmp      = (state == ST_CMP);
    cmd.ins      = (state == ST_ACT) && is_ins_pass && ins_ok;
    cmd.del      = (state == ST_ACT) && is_del_pass;
    cmd.srch     = (state == ST_ACT) && (cur.kind == KIND_SEARCH);
    cmd.fetch    = (state == ST_ACT) && (cur.kind == KIND_FETCH);
    cmd.score    = ((cur.kind == KIND_UPDATE) && !second) ? cur.prior_score : cur.score;
    cmd.value    = cur.value;
    cmd.position = cur.position;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_gt;
    logic   left_eq;

    if (i == 0) begin : g_head
      assign left_ent = '0;
      assign left_gt  = 1'b0;
      assign left_eq  = 1'b0;
    end else begin : g_body
      assign left_ent = ents[i-1];
      assign left_gt  = gts[i-1];
      assign left_eq  = eqs[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_next
      assign right_ent = ents[i+1];
    end

    rspt_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (entry_count),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .left_gt   (left_gt),
      .left_eq   (left_eq),
      .seen_in   (seen[i]),
      .ent       (ents[i]),
      .gt        (gts[i]),
      .eq        (eqs[i]),
      .seen_out  (seen[i+1]),
      .hit       (hits[i])
    );
  end

  rspt_select #(
    .N (CAPACITY)
  ) u_select (
    .clk  (clk),
    .load (state == ST_ACT),
    .hit  (hits),
    .ents (ents),
    .any  (sel_any),
    .rank (sel_rank),
    .ent  (sel_ent)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      second      <= 1'b0;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            cur    <= req;
            second <= 1'b0;
            state  <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_ACT;
        end
        ST_ACT: begin
          if (is_ins_pass) begin
            entry_count <= entry_count + CNT_W'(ins_ok);
            res_status  <= ins_ok ? STATUS_OK : STATUS_FULL;
            state       <= ST_DONE;
          end else if (is_del_pass) begin
            entry_count <= entry_count - CNT_W'(found);
            res_status  <= found ? STATUS_OK : STATUS_NOT_FOUND;
            // Update runs its insert pass after the delete pass.
            if (cur.kind == KIND_UPDATE) begin
              second <= 1'b1;
              state  <= ST_CMP;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            res_status <= STATUS_NOT_FOUND;
            state      <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold until the output register is free.
          if (rsp_load) begin
            rsp.status      <= is_query ? (sel_any ? STATUS_OK : STATUS_NOT_FOUND)
                                        : res_status;
            rsp.rank        <= (is_query && sel_any) ? sel_rank : 9'd0;
            rsp.found_score <= (is_query && sel_any) ? sel_ent.score : 32'sd0;
            rsp.found_value <= (is_query && sel_any) ? sel_ent.value : 32'sd0;
            rsp.entry_total <= 9'(entry_count);
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACT) |-> $onehot0(hits))
    else $error("more than one cell flagged");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == ST_CMP))
    else $error("accepted transaction did not start a compare");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> (entry_count == $past(entry_count) + CNT_W'(1)))
    else $error("insert did not grow the count");

endmodule

FILE: verif/rspt_table_checker.sv
// ----------------------------------------------------------------------------
// rspt_table_checker: scoreboard for the ranked sorted pair table
// Watches both channels and keeps its own sorted copy of the table. Each
// accepted request is turned into an expected response, and each accepted
// response is compared field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module rspt_table_checker
  import rspt_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending_count
);

  logic signed [31:0] held_scores [CAPACITY];
  logic signed [31:0] held_values [CAPACITY];
  int                 held_count;
  rsp_t               expected_rsp_q [$];
  rsp_t               want;

  // New pair goes after every pair whose score is at most its own.
  function automatic logic [1:0] insert_pair(logic signed [31:0] s, logic signed [31:0] v);
    int pos;
    int i;
    pos = 0;
    if (held_count >= CAPACITY) return STATUS_FULL;
    while (pos < held_count && held_scores[pos] <= s) pos++;
    for (i = held_count; i > pos; i--) begin
      held_scores[i] = held_scores[i - 1];
      held_values[i] = held_values[i - 1];
    end
    held_scores[pos] = s;
    held_values[pos] = v;
    held_count++;
    return STATUS_OK;
  endfunction

  // Remove the first pair that matches both score and value.
  function automatic logic [1:0] delete_pair(logic signed [31:0] s, logic signed [31:0] v);
    int i;
    int j;
    for (i = 0; i < held_count; i++) begin
      if (held_scores[i] == s && held_values[i] == v) begin
        for (j = i; j < held_count - 1; j++) begin
          held_scores[j] = held_scores[j + 1];
          held_values[j] = held_values[j + 1];
        end
        held_count--;
        return STATUS_OK;
      end
    end
    return STATUS_NOT_FOUND;
  endfunction

  function automatic rsp_t predict_table_op(req_t op);
    rsp_t               res;
    logic signed [31:0] key;
    logic signed [31:0] val;
    logic signed [31:0] old_key;
    int                 i;
    res        = '0;
    res.status = STATUS_NOT_FOUND;
    key        = op.score;
    val        = op.value;
    old_key    = op.prior_score;
    case (op.kind)
      KIND_INSERT: res.status = insert_pair(key, val);
      KIND_DELETE: res.status = delete_pair(key, val);
      KIND_UPDATE: begin
        // a failed delete does not show in the status
        void'(delete_pair(old_key, val));
        res.status = insert_pair(key, val);
      end
      KIND_SEARCH: begin
        for (i = 0; i < held_count; i++) begin
          if (held_scores[i] == key) begin
            res.status      = STATUS_OK;
            res.rank        = 9'(i + 1);
            res.found_score = held_scores[i];
            res.found_value = held_values[i];
            break;
          end
        end
      end
      KIND_FETCH: begin
        if (op.position >= 1 && int'(op.position) <= held_count) begin
          res.status      = STATUS_OK;
          res.rank        = op.position;
          res.found_score = held_scores[op.position - 1];
          res.found_value = held_values[op.position - 1];
        end
      end
      default: ;
    endcase
    res.entry_total = 9'(held_count);
    return res;
  endfunction

  task automatic check_field(string name, longint exp_val, longint got_val);
    if (exp_val != got_val) begin
      $error("rsp.%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  // Compare before pushing so a response always pairs with an older request.
  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      expected_rsp_q.delete();
      fail_count = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response transaction with no request outstanding");
          fail_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("rank", want.rank, rsp.rank);
          check_field("found_score", $signed(want.found_score), $signed(rsp.found_score));
          check_field("found_value", $signed(want.found_value), $signed(rsp.found_value));
          check_field("entry_total", want.entry_total, rsp.entry_total);
        end
      end
      if (req_valid && req_ready) expected_rsp_q.push_back(predict_table_op(req));
    end
    pending_count = expected_rsp_q.size();
  end

endmodule

FILE: verif/ranked_sorted_pair_table_tb.sv
// ----------------------------------------------------------------------------
// ranked_sorted_pair_table_tb: stimulus and verdict for the sorted pair table
// Runs directed operations on the corner cases, then random phases that fill
// the table to capacity, drain it and mix all operations, with random idling
// on both channels in the first two phases. Checking is done by the scoreboard beside the block.
// ----------------------------------------------------------------------------
module ranked_sorted_pair_table_tb
  import rspt_pkg::*;
();

  localparam int TABLE_DEPTH   = 256;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;

  localparam logic [2:0] KIND_SPARE_A = 3'd5;
  localparam logic [2:0] KIND_SPARE_B = 3'd6;
  localparam logic [2:0] KIND_SPARE_C = 3'd7;

  localparam logic signed [31:0] SCORE_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] SCORE_HIGH = 32'sh7FFF_FFFE;
  localparam logic signed [31:0] SCORE_MAX  = 32'sh7FFF_FFFF;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  req_t req       = '0;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp;

  int fail_count;
  int pending_count;
  int tx_idle_pct = 26;
  int rx_idle_pct = 63;
  int cycle_count = 0;

  // pairs believed to be held; may go stale, which only adds noise
  entry_t known_pairs [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ranked_sorted_pair_table #(
    .CAPACITY (TABLE_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  rspt_table_checker #(
    .CAPACITY (TABLE_DEPTH)
  ) checker_inst (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_score();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return SCORE_MIN;
          1: return SCORE_HIGH;
          2: return SCORE_MAX;
          3: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      1, 2: return $urandom;
      default: return 32'($urandom_range(0, 16)) - 32'd8;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 1) == 0) return 32'($urandom_range(0, 3));
    return $urandom;
  endfunction

  function automatic req_t make_req(logic [2:0] kind, logic signed [31:0] score,
                                    logic signed [31:0] value,
                                    logic signed [31:0] prior_score,
                                    logic [8:0] position);
    req_t op;
    op.kind        = kind;
    op.score       = score;
    op.value       = value;
    op.prior_score = prior_score;
    op.position    = position;
    return op;
  endfunction

  function automatic void remember_pair(logic signed [31:0] s, logic signed [31:0] v);
    entry_t pair;
    pair.score = s;
    pair.value = v;
    if (known_pairs.size() < 1024) known_pairs.push_back(pair);
  endfunction

  // Draw one operation; the percentages weight insert, delete and update.
  function automatic req_t make_op(int ins_pct, int del_pct, int upd_pct);
    req_t op;
    int   roll;
    int   idx;
    int   hi_pos;
    op   = make_req(KIND_INSERT, pick_score(), pick_value(), pick_score(),
                    9'($urandom_range(0, TABLE_DEPTH)));
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      remember_pair(op.score, op.value);
    end else if (roll < ins_pct + del_pct) begin
      op.kind = KIND_DELETE;
      if (known_pairs.size() > 0 && $urandom_range(0, 4) != 0) begin
        idx      = $urandom_range(0, known_pairs.size() - 1);
        op.score = known_pairs[idx].score;
        op.value = known_pairs[idx].value;
        known_pairs.delete(idx);
      end
    end else if (roll < ins_pct + del_pct + upd_pct) begin
      op.kind = KIND_UPDATE;
      if (known_pairs.size() > 0 && $urandom_range(0, 4) != 0) begin
        idx            = $urandom_range(0, known_pairs.size() - 1);
        op.prior_score = known_pairs[idx].score;
        op.value       = known_pairs[idx].value;
        known_pairs.delete(idx);
      end
      remember_pair(op.score, op.value);
    end else if (roll == 99) begin
      op.kind = KIND_SPARE_A + 3'($urandom_range(0, 2));
    end else if (roll[0]) begin
      op.kind = KIND_SEARCH;
      if (known_pairs.size() > 0 && $urandom_range(0, 4) < 3)
        op.score = known_pairs[$urandom_range(0, known_pairs.size() - 1)].score;
    end else begin
      op.kind = KIND_FETCH;
      hi_pos  = (known_pairs.size() > TABLE_DEPTH) ? TABLE_DEPTH : known_pairs.size();
      if (hi_pos < 1) hi_pos = 1;
      case ($urandom_range(0, 3))
        0: op.position = 9'($urandom_range(0, TABLE_DEPTH));
        3: op.position = ($urandom_range(0, 1) == 0) ? 9'(TABLE_DEPTH) : 9'd0;
        default: op.position = 9'($urandom_range(1, hi_pos));
      endcase
    end
    return op;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still
  // high, so the next call or the caller drives valid exactly once.
  task automatic send_op(req_t op);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= op;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic run_random(int count, int ins_pct, int del_pct, int upd_pct);
    repeat (count) send_op(make_op(ins_pct, del_pct, upd_pct));
    wait_drained();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table: every lookup misses, update still inserts
    send_op(make_req(KIND_SEARCH, 32'sd5, 32'sd0, 32'sd0, 9'd0));
    send_op(make_req(KIND_FETCH, 32'sd0, 32'sd0, 32'sd0, 9'd1));
    send_op(make_req(KIND_DELETE, 32'sd0, 32'sd0, 32'sd0, 9'd0));
    send_op(make_req(KIND_UPDATE, 32'sd3, 32'sd9, 32'sd7, 9'd0));
    // score extremes and equal scores in arrival order
    send_op(make_req(KIND_INSERT, SCORE_MIN, 32'sd1, 32'sd0, 9'd0));
    send_op(make_req(KIND_INSERT, SCORE_MAX, 32'sd2, 32'sd0, 9'd0));
    send_op(make_req(KIND_INSERT, SCORE_HIGH, SCORE_MIN, 32'sd0, 9'd0));
    send_op(make_req(KIND_INSERT, 32'sd3, 32'sd10, 32'sd0, 9'd0));
    send_op(make_req(KIND_INSERT, 32'sd3, SCORE_MAX, 32'sd0, 9'd0));
    send_op(make_req(KIND_SEARCH, 32'sd3, 32'sd0, 32'sd0, 9'd0));
    send_op(make_req(KIND_FETCH, 32'sd0, 32'sd0, 32'sd0, 9'd1));
    send_op(make_req(KIND_FETCH, 32'sd0, 32'sd0, 32'sd0, 9'd6));
    send_op(make_req(KIND_FETCH, 32'sd0, 32'sd0, 32'sd0, 9'd7));
    send_op(make_req(KIND_FETCH, 32'sd0, 32'sd0, 32'sd0, 9'd0));
    send_op(make_req(KIND_FETCH, 32'sd0, 32'sd0, 32'sd0, 9'(TABLE_DEPTH)));
    send_op(make_req(KIND_DELETE, 32'sd3, 32'sd99, 32'sd0, 9'd0));
    send_op(make_req(KIND_DELETE, 32'sd3, 32'sd10, 32'sd0, 9'd0));
    send_op(make_req(KIND_UPDATE, -32'sd1, SCORE_MAX, 32'sd3, 9'd0));
    send_op(make_req(KIND_UPDATE, SCORE_MAX, 32'sd9, 32'sd3, 9'd0));
    send_op(make_req(KIND_SEARCH, SCORE_MAX, 32'sd0, 32'sd0, 9'd0));
    send_op(make_req(KIND_SEARCH, SCORE_MIN, 32'sd0, 32'sd0, 9'd0));
    send_op(make_req(KIND_SPARE_A, 32'sd3, 32'sd9, 32'sd3, 9'd1));
    send_op(make_req(KIND_SPARE_B, SCORE_MAX, 32'sd2, 32'sd0, 9'd2));
    send_op(make_req(KIND_SPARE_C, -32'sd1, -32'sd1, -32'sd1, 9'h1FF));
    send_op(make_req(KIND_DELETE, SCORE_MIN, 32'sd1, 32'sd0, 9'd0));
    wait_drained();

    // fill past capacity so inserts and updates hit a full table
    run_random(400, 75, 5, 5);

    tx_idle_pct = 63;
    rx_idle_pct = 26;
    run_random(300, 15, 45, 10);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(200, 30, 25, 15);

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: ranked_sorted_pair_table.f
sv/rspt_pkg.sv
sv/rspt_cell.sv
sv/rspt_select.sv
sv/ranked_sorted_pair_table.sv
verif/rspt_table_checker.sv
verif/ranked_sorted_pair_table_tb.sv
